/* rtl/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Shared types, codes and helpers for the SPI-mode card init and block read.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

    // Request kinds on the input channel.
    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;

    // Completion status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RST_TMO   = 3'd1;
    localparam logic [2:0] ST_OPC_TMO   = 3'd2;
    localparam logic [2:0] ST_RESP_TMO  = 3'd3;
    localparam logic [2:0] ST_TOKEN_TMO = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_OP_RETRIES = 2'd1;
    localparam logic [1:0] CFG_WAKE_BYTES = 2'd2;

    localparam logic [15:0] POLL_LIMIT_RST = 16'h0FFF;
    localparam logic [7:0]  OP_RETRIES_RST = 8'hFF;
    localparam logic [7:0]  WAKE_BYTES_RST = 8'd10;

    // Command bytes and fixed values.
    localparam logic [7:0] CMD0_BYTE   = 8'h40;
    localparam logic [7:0] CMD1_BYTE   = 8'h41;
    localparam logic [7:0] CMD16_BYTE  = 8'h50;
    localparam logic [7:0] CMD17_BYTE  = 8'h51;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_DUMMY   = 8'hFF;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_WAKE,
        PH_CMD0,
        PH_POLL0,
        PH_GAPA,
        PH_CMD1,
        PH_POLL1,
        PH_GAPB,
        PH_CMD16,
        PH_POLL16,
        PH_TAILI,
        PH_CMD17,
        PH_POLLR,
        PH_POLLT,
        PH_DATA,
        PH_CRC,
        PH_TAILR
    } phase_t;

    typedef struct packed {
        logic [15:0] poll_limit;
        logic [7:0]  op_cond_retries;
        logic [7:0]  wake_bytes;
    } cfg_t;

    typedef struct packed {
        logic       xfer_req;
        logic [7:0] tx_byte;
        logic       card_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       done_res;
        logic [2:0] status;
        logic       busy_res;
    } res_t;

    // One byte of a six-byte command frame: command, argument MSB first, CRC.
    function automatic logic [7:0] frame_byte(
        input logic [7:0]  cmd,
        input logic [31:0] arg,
        input logic [7:0]  crc,
        input logic [2:0]  idx
    );
        logic [7:0] b;
        case (idx)
            3'd0:    b = cmd;
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = crc;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/sdspi_cfg.sv */
// ----------------------------------------------------------------------------
// SD SPI configuration registers
// Holds poll limit, CMD1 retry count and wake byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_cfg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output sdspi_pkg::cfg_t         cfg
);

    sdspi_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit      <= sdspi_pkg::POLL_LIMIT_RST;
            cfg_reg.op_cond_retries <= sdspi_pkg::OP_RETRIES_RST;
            cfg_reg.wake_bytes      <= sdspi_pkg::WAKE_BYTES_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdspi_pkg::CFG_POLL_LIMIT: cfg_reg.poll_limit      <= cfg_data;
                sdspi_pkg::CFG_OP_RETRIES: cfg_reg.op_cond_retries <= cfg_data[7:0];
                sdspi_pkg::CFG_WAKE_BYTES: cfg_reg.wake_bytes      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/sdspi_seq.sv */
// ----------------------------------------------------------------------------
// SD SPI command sequencer
// Phase state and counters, advanced once per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_seq #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [1:0]         action,
    input  wire logic [22:0]        block_idx,
    input  wire logic [7:0]         rx_byte,
    input  wire sdspi_pkg::cfg_t    cfg,
    output sdspi_pkg::res_t         res
);

    localparam int BCW_DATA = $clog2(BLOCK_BYTES + 1);
    localparam int BCW      = (BCW_DATA > 8) ? BCW_DATA : 8;

    sdspi_pkg::phase_t phase_reg, phase_next;
    logic [BCW-1:0]    byte_count_reg, byte_count_next;
    logic [15:0]       poll_count_reg, poll_count_next;
    logic [7:0]        retry_count_reg, retry_count_next;
    logic              select_reg, select_next;
    logic [31:0]       byte_address_reg, byte_address_next;

    logic [BCW-1:0]    byte_inc;
    logic [15:0]       poll_inc;
    logic [15:0]       poll_lim;
    logic              poll_out;
    logic [7:0]        retry_inc;
    logic [7:0]        retry_lim;
    logic [7:0]        wake_lim;
    logic              req;
    logic              done;
    logic              dv;
    logic              dl;
    logic [2:0]        st;
    logic [7:0]        tx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sdspi_pkg::PH_IDLE;
            byte_count_reg   <= '0;
            poll_count_reg   <= '0;
            retry_count_reg  <= '0;
            select_reg       <= 1'b0;
            byte_address_reg <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            poll_count_reg   <= poll_count_next;
            retry_count_reg  <= retry_count_next;
            select_reg       <= select_next;
            byte_address_reg <= byte_address_next;
        end
    end

    // A limit register of zero behaves as one.
    always_comb
    begin
        byte_inc  = byte_count_reg + BCW'(1);
        poll_inc  = poll_count_reg + 16'd1;
        retry_inc = retry_count_reg + 8'd1;
        poll_lim  = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
        retry_lim = (cfg.op_cond_retries == 8'd0) ? 8'd1 : cfg.op_cond_retries;
        wake_lim  = (cfg.wake_bytes == 8'd0) ? 8'd1 : cfg.wake_bytes;
        poll_out  = (poll_inc >= poll_lim) || (poll_inc == 16'd0);
    end

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        poll_count_next   = poll_count_reg;
        retry_count_next  = retry_count_reg;
        select_next       = select_reg;
        byte_address_next = byte_address_reg;
        req  = 1'b0;
        done = 1'b0;
        dv   = 1'b0;
        dl   = 1'b0;
        st   = sdspi_pkg::ST_OK;

        if (action == sdspi_pkg::ACT_INIT || action == sdspi_pkg::ACT_READ)
        begin
            // Starts are ignored while an operation is running.
            if (phase_reg == sdspi_pkg::PH_IDLE)
            begin
                byte_count_next = '0;
                poll_count_next = '0;
                req             = 1'b1;
                if (action == sdspi_pkg::ACT_INIT)
                begin
                    phase_next       = sdspi_pkg::PH_WAKE;
                    retry_count_next = '0;
                    select_next      = 1'b0;
                end
                else
                begin
                    phase_next        = sdspi_pkg::PH_CMD17;
                    byte_address_next = 32'({9'd0, block_idx} * 32'(BLOCK_BYTES));
                    select_next       = 1'b1;
                end
            end
        end
        else if (action == sdspi_pkg::ACT_BYTE && phase_reg != sdspi_pkg::PH_IDLE)
        begin
            case (phase_reg)
                sdspi_pkg::PH_WAKE:
                begin
                    byte_count_next = byte_inc;
                    if (byte_inc >= BCW'(wake_lim))
                    begin
                        phase_next      = sdspi_pkg::PH_CMD0;
                        byte_count_next = '0;
                        poll_count_next = '0;
                        select_next     = 1'b1;
                    end
                end
                sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD1,
                sdspi_pkg::PH_CMD16, sdspi_pkg::PH_CMD17:
                begin
                    byte_count_next = byte_inc;
                    if (byte_inc >= BCW'(6))
                    begin
                        byte_count_next = '0;
                        poll_count_next = '0;
                        case (phase_reg)
                            sdspi_pkg::PH_CMD0:  phase_next = sdspi_pkg::PH_POLL0;
                            sdspi_pkg::PH_CMD1:  phase_next = sdspi_pkg::PH_POLL1;
                            sdspi_pkg::PH_CMD16: phase_next = sdspi_pkg::PH_POLL16;
                            default:             phase_next = sdspi_pkg::PH_POLLR;
                        endcase
                    end
                end
                sdspi_pkg::PH_POLL0:
                begin
                    if (rx_byte == sdspi_pkg::R1_IDLE)
                    begin
                        phase_next      = sdspi_pkg::PH_GAPA;
                        byte_count_next = '0;
                        poll_count_next = '0;
                    end
                    else
                    begin
                        poll_count_next = poll_inc;
                        if (poll_out)
                        begin
                            done = 1'b1;
                            st   = sdspi_pkg::ST_RST_TMO;
                        end
                    end
                end
                sdspi_pkg::PH_GAPA, sdspi_pkg::PH_GAPB, sdspi_pkg::PH_TAILI:
                begin
                    // First gap byte goes out selected, the rest deselected.
                    byte_count_next = byte_inc;
                    if (byte_inc == BCW'(1))
                        select_next = 1'b0;
                    if (byte_inc >= BCW'(3))
                    begin
                        if (phase_reg == sdspi_pkg::PH_TAILI)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            select_next     = 1'b1;
                            byte_count_next = '0;
                            poll_count_next = '0;
                            if (phase_reg == sdspi_pkg::PH_GAPA)
                            begin
                                retry_count_next = '0;
                                phase_next       = sdspi_pkg::PH_CMD1;
                            end
                            else
                            begin
                                phase_next = sdspi_pkg::PH_CMD16;
                            end
                        end
                    end
                end
                sdspi_pkg::PH_POLL1:
                begin
                    if (rx_byte == sdspi_pkg::R1_READY)
                    begin
                        phase_next      = sdspi_pkg::PH_GAPB;
                        byte_count_next = '0;
                        poll_count_next = '0;
                    end
                    else
                    begin
                        poll_count_next = poll_inc;
                        if (poll_out)
                        begin
                            retry_count_next = retry_inc;
                            if (retry_inc >= retry_lim || retry_inc == 8'd0)
                            begin
                                done = 1'b1;
                                st   = sdspi_pkg::ST_OPC_TMO;
                            end
                            else
                            begin
                                phase_next      = sdspi_pkg::PH_CMD1;
                                byte_count_next = '0;
                                poll_count_next = '0;
                            end
                        end
                    end
                end
                sdspi_pkg::PH_POLL16:
                begin
                    // A missing CMD16 response does not stop the init.
                    if (rx_byte == sdspi_pkg::R1_READY || poll_out)
                    begin
                        phase_next      = sdspi_pkg::PH_TAILI;
                        byte_count_next = '0;
                        poll_count_next = '0;
                    end
                    else
                    begin
                        poll_count_next = poll_inc;
                    end
                end
                sdspi_pkg::PH_POLLR:
                begin
                    if (rx_byte == sdspi_pkg::R1_READY)
                    begin
                        phase_next      = sdspi_pkg::PH_POLLT;
                        byte_count_next = '0;
                        poll_count_next = '0;
                    end
                    else
                    begin
                        poll_count_next = poll_inc;
                        if (poll_out)
                        begin
                            done = 1'b1;
                            st   = sdspi_pkg::ST_RESP_TMO;
                        end
                    end
                end
                sdspi_pkg::PH_POLLT:
                begin
                    if (rx_byte == sdspi_pkg::DATA_TOKEN)
                    begin
                        phase_next      = sdspi_pkg::PH_DATA;
                        byte_count_next = '0;
                        poll_count_next = '0;
                    end
                    else
                    begin
                        poll_count_next = poll_inc;
                        if (poll_out)
                        begin
                            done = 1'b1;
                            st   = sdspi_pkg::ST_TOKEN_TMO;
                        end
                    end
                end
                sdspi_pkg::PH_DATA:
                begin
                    dv              = 1'b1;
                    byte_count_next = byte_inc;
                    if (byte_inc >= BCW'(BLOCK_BYTES))
                    begin
                        dl              = 1'b1;
                        phase_next      = sdspi_pkg::PH_CRC;
                        byte_count_next = '0;
                        poll_count_next = '0;
                    end
                end
                sdspi_pkg::PH_CRC:
                begin
                    byte_count_next = byte_inc;
                    if (byte_inc >= BCW'(2))
                    begin
                        phase_next      = sdspi_pkg::PH_TAILR;
                        byte_count_next = '0;
                        poll_count_next = '0;
                        select_next     = 1'b0;
                    end
                end
                sdspi_pkg::PH_TAILR:
                begin
                    done = 1'b1;
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase

            if (done)
            begin
                phase_next      = sdspi_pkg::PH_IDLE;
                byte_count_next = '0;
                poll_count_next = '0;
            end
            else
            begin
                req = 1'b1;
            end
        end
    end

    // The byte to send follows the phase and count that this request leaves.
    always_comb
    begin
        case (phase_next)
            sdspi_pkg::PH_CMD0:
                tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD0_BYTE, 32'd0,
                                           sdspi_pkg::CRC_CMD0, byte_count_next[2:0]);
            sdspi_pkg::PH_CMD1:
                tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD1_BYTE, 32'd0,
                                           sdspi_pkg::CRC_DUMMY, byte_count_next[2:0]);
            sdspi_pkg::PH_CMD16:
                tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD16_BYTE, 32'(BLOCK_BYTES),
                                           sdspi_pkg::CRC_DUMMY, byte_count_next[2:0]);
            sdspi_pkg::PH_CMD17:
                tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD17_BYTE, byte_address_next,
                                           sdspi_pkg::CRC_DUMMY, byte_count_next[2:0]);
            default:
                tx = sdspi_pkg::IDLE_BYTE;
        endcase
    end

    always_comb
    begin
        res.xfer_req    = req;
        res.tx_byte     = req ? tx : 8'd0;
        res.card_select = select_next;
        res.data_valid  = dv;
        res.data_byte   = dv ? rx_byte : 8'd0;
        res.data_last   = dl;
        res.done_res    = done;
        res.status      = st;
        res.busy_res    = (phase_next != sdspi_pkg::PH_IDLE);
    end

endmodule

`default_nettype wire

/* rtl/sd_spi_init_and_block_read_top.sv */
// ----------------------------------------------------------------------------
// SD card SPI-mode init and single block read sequencer
// Drives a byte-wide SPI link: one result request per byte exchange.
// ----------------------------------------------------------------------------
// Usage: send a request with tuser = 0 to start card init, or 1 to start a
// block read (block number in tdata). Each result request with xfer_req set
// asks the link to exchange tx_byte with the given chip-select level; the
// byte received goes back as the next input request with tuser = 2.
// Block data bytes come out with data_valid set; tlast marks the final one.
// done_res with status ends an operation.
// Every input request gives exactly one result request. The result is
// registered in the output register on acceptance; a new request can be
// accepted every cycle, also while the previous result is being taken.
// When the receiver stalls, the output register holds and tready on the
// input drops, so no request is accepted until a result slot frees up.
// Reset returns the sequencer to idle with the card deselected and the
// configuration registers at their defaults. The configuration port takes a
// write every cycle and is meant to be used while the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_init_and_block_read_top #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // block index[22:0], rx_byte[30:23]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // tx_byte[7:0], card_select[8],
                                             // data_byte[16:9], status[19:17],
                                             // busy_res[20]
    output logic [2:0]       m_axis_tuser,   // xfer_req[0], data_valid[1], done_res[2]
    output logic             m_axis_tlast,   // data_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    sdspi_pkg::cfg_t cfg;
    sdspi_pkg::res_t res;
    sdspi_pkg::res_t res_reg;
    logic            out_valid_reg;
    logic            step;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    sdspi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdspi_seq #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .action       (s_axis_tuser),
        .block_idx    (s_axis_tdata[22:0]),
        .rx_byte      (s_axis_tdata[30:23]),
        .cfg          (cfg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, res_reg.busy_res, res_reg.status, res_reg.data_byte,
                            res_reg.card_select, res_reg.tx_byte};
    assign m_axis_tuser  = {res_reg.done_res, res_reg.data_valid, res_reg.xfer_req};
    assign m_axis_tlast  = res_reg.data_last;

endmodule

`default_nettype wire
